>>> src/periodic_timer_bank_defines.svh
// Assertion macros shared by the timer bank RTL.
`ifndef PERIODIC_TIMER_BANK_DEFINES_SVH
`define PERIODIC_TIMER_BANK_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge of clk outside reset.
`define PTB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every rising edge of clk, reset included.
`define PTB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTB_ASSERT(label, prop, msg)
`define PTB_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> src/ptb_pkg.sv
package ptb_pkg;

	localparam int NUM_TIMERS = 3;

	localparam int KIND_W     = 2;
	localparam int SLOT_W     = 2;
	localparam int INTERVAL_W = 16;
	localparam int MASK_W     = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK       = 2'd0,
		KIND_CREATE     = 2'd1,
		KIND_RELEASE    = 2'd2,
		KIND_SET_RELOAD = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

>>> src/ptb_ctrl.sv
module ptb_ctrl
	import ptb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The result register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = (state_q == ST_IDLE) && in_valid;
	assign cmd.execute = (state_q == ST_EXEC) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/ptb_datapath.sv
module ptb_datapath
	import ptb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic [KIND_W-1:0]     kind,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [INTERVAL_W-1:0] interval,
	output logic [MASK_W-1:0]     expired_mask,
	output logic                  create_ok,
	output logic [SLOT_W-1:0]     granted_slot
);

	kind_t                  kind_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [INTERVAL_W-1:0]  interval_q;

	logic [INTERVAL_W-1:0]  count_q  [NUM_TIMERS];
	logic [INTERVAL_W-1:0]  reload_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  enabled_q;

	logic [MASK_W-1:0]      mask_q;
	logic                   ok_q;
	logic [SLOT_W-1:0]      granted_q;

	logic [NUM_TIMERS-1:0]  is_tick_hit;
	logic [NUM_TIMERS-1:0]  expired;
	logic [NUM_TIMERS-1:0]  free;
	logic [NUM_TIMERS-1:0]  grant_oh;
	logic [NUM_TIMERS-1:0]  slot_oh;
	logic [MASK_W-1:0]      mask_d;
	logic [SLOT_W-1:0]      granted_d;
	logic                   do_tick;
	logic                   do_create;
	logic                   do_release;
	logic                   do_reload;

	assign do_tick    = cmd.execute && (kind_q == KIND_TICK);
	assign do_create  = cmd.execute && (kind_q == KIND_CREATE);
	assign do_release = cmd.execute && (kind_q == KIND_RELEASE);
	assign do_reload  = cmd.execute && (kind_q == KIND_SET_RELOAD);

	// Lowest free slot as a one-hot vector; zero when the bank is full.
	assign free     = ~enabled_q;
	assign grant_oh = free & (~free + NUM_TIMERS'(1));

	// A slot number beyond the bank shifts out and selects nothing.
	assign slot_oh = NUM_TIMERS'(1) << slot_q;

	assign is_tick_hit = enabled_q;

	always_comb begin
		mask_d    = '0;
		granted_d = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (expired[i]) begin
				mask_d = mask_d | (MASK_W'(1) << i);
			end
			if (grant_oh[i]) begin
				granted_d = granted_d | SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q     <= kind_t'(kind);
			slot_q     <= slot;
			interval_q <= interval;
		end
	end

	for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_slot
		logic [INTERVAL_W-1:0] dec;

		assign dec        = count_q[g] - INTERVAL_W'(1);
		assign expired[g] = is_tick_hit[g] && (dec == '0);

		always_ff @(posedge clk) begin
			if (do_tick && is_tick_hit[g]) begin
				count_q[g] <= (dec == '0) ? reload_q[g] : dec;
			end else if (do_create && grant_oh[g]) begin
				count_q[g] <= interval_q;
			end
			if ((do_create && grant_oh[g]) || (do_reload && slot_oh[g])) begin
				reload_q[g] <= interval_q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				enabled_q[g] <= 1'b0;
			end else if (do_create && grant_oh[g]) begin
				enabled_q[g] <= 1'b1;
			end else if (do_release && slot_oh[g]) begin
				enabled_q[g] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			case (kind_q)
				KIND_TICK: begin
					mask_q    <= mask_d;
					ok_q      <= 1'b0;
					granted_q <= '0;
				end
				KIND_CREATE: begin
					mask_q    <= '0;
					ok_q      <= |grant_oh;
					granted_q <= granted_d;
				end
				KIND_RELEASE, KIND_SET_RELOAD: begin
					mask_q    <= '0;
					ok_q      <= 1'b0;
					granted_q <= '0;
				end
				default: begin
					mask_q    <= '0;
					ok_q      <= 1'b0;
					granted_q <= '0;
				end
			endcase
		end
	end

	assign expired_mask = mask_q;
	assign create_ok    = ok_q;
	assign granted_slot = granted_q;

endmodule

>>> src/periodic_timer_bank.sv
// Bank of periodic down-counting timers.
// Input channel (in_valid, in_stall, kind, slot, interval): one command per
// transfer: tick, create, release or set-reload. Output channel (out_valid,
// out_stall, expired_mask, create_ok, granted_slot): exactly one result per
// command, in command order.
// A command taken into the item register is executed, and its result loaded
// into the result register, once that register is free.
// The controller takes a command into the item register, then in the execute
// state updates all slots in parallel and loads the result register; in_stall
// is high in that state, so no new command is taken before the last one is done.
// When the receiver holds out_stall, the result stays on the port; one more
// command is taken and then waits in the execute state until the result
// register drains, so in_stall stays high meanwhile.
// Reset clears all enable bits and empties the result register; counts and
// reload values are written by create before they are ever used.
`include "periodic_timer_bank_defines.svh"

module periodic_timer_bank
	import ptb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [KIND_W-1:0]     kind,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [INTERVAL_W-1:0] interval,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [MASK_W-1:0]     expired_mask,
	output logic                  create_ok,
	output logic [SLOT_W-1:0]     granted_slot
);

	cmd_t cmd;

	ptb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ptb_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (kind),
		.slot         (slot),
		.interval     (interval),
		.expired_mask (expired_mask),
		.create_ok    (create_ok),
		.granted_slot (granted_slot)
	);

	// In the cycle after a transfer in, the controller is busy.
	`PTB_ASSERT(a_busy_after_take, (in_valid && !in_stall) |=> in_stall, "command taken while busy")
	// A failed create or any other command reports slot zero.
	`PTB_ASSERT(a_grant_zero, (out_valid && !create_ok) |-> (granted_slot == '0), "stray granted slot")
	// Expiries and a successful create never share one result.
	`PTB_ASSERT(a_mask_vs_ok, (out_valid && (expired_mask != '0)) |-> !create_ok, "mixed result kinds")
	// Only one of capture and execute can be issued in a cycle.
	`PTB_ASSERT_ALWAYS(a_cmd_excl, !(cmd.capture && cmd.execute), "capture and execute together")

endmodule
